/* rtl/core/plfm_pkg.sv */
// Package for the price-level FIFO order matcher.
// Holds the command, result and status codes and the control structs that
// join the controller and the datapath. Depends on nothing.
package plfm_pkg;

  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_CANCEL  = 2'd1;
  localparam logic [1:0] CMD_CONSUME = 2'd2;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_FILL   = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_REJECT    = 2'd2;

  typedef struct packed {
    logic clr_we;
    logic load_item;
    logic ht_load;
    logic add_exec;
    logic cancel_exec;
    logic pop;
    logic fill_exec;
    logic done_exec;
  } plfm_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       out_free;
    logic [1:0] cmd;
    logic       cons_stop;
    logic       entry_active;
  } plfm_stat_t;

endpackage

/* rtl/core/plfm_if.sv */
// Channel interfaces of the order matcher: the command channel and the result
// channel, each with valid, ready and payload. Depends on nothing.
interface plfm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic        side;
  logic [11:0] ord_id;
  logic [5:0]  price_level;
  logic [31:0] exec_price;
  logic [31:0] quantity;

  modport source (output valid, command, side, ord_id, price_level, exec_price, quantity,
                  input ready);
  modport sink (input valid, command, side, ord_id, price_level, exec_price, quantity,
                output ready);
endinterface

interface plfm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  status;
  logic [11:0] buy_order_id;
  logic [11:0] sell_order_id;
  logic [31:0] fill_price;
  logic [31:0] fill_quantity;
  logic [31:0] remaining_quantity;
  logic        level_now_empty;
  logic        last;

  modport source (output valid, kind, status, buy_order_id, sell_order_id, fill_price,
                  fill_quantity, remaining_quantity, level_now_empty, last,
                  input ready);
  modport sink (input valid, kind, status, buy_order_id, sell_order_id, fill_price,
                fill_quantity, remaining_quantity, level_now_empty, last,
                output ready);
endinterface

/* rtl/core/plfm_ctrl.sv */
// Controller state machine of the order matcher.
// Sequences lookups, table updates and the consume walk. Depends on plfm_pkg.
module plfm_ctrl
  import plfm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  plfm_stat_t stat,
  output plfm_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_LOOKUP = 8'b0000_0100,
    S_EXEC   = 8'b0000_1000,
    S_CLOAD  = 8'b0001_0000,
    S_CTEST  = 8'b0010_0000,
    S_CPROC  = 8'b0100_0000,
    S_CDONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        unique case (stat.cmd)
          CMD_CONSUME:        state_nxt = S_CLOAD;
          CMD_ADD, CMD_CANCEL: state_nxt = S_EXEC;
          default:            state_nxt = S_IDLE;
        endcase
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.add_exec    = (stat.cmd == CMD_ADD);
          cmd.cancel_exec = (stat.cmd != CMD_ADD);
          state_nxt       = S_IDLE;
        end
      end
      S_CLOAD: begin
        cmd.ht_load = 1'b1;
        state_nxt   = S_CTEST;
      end
      S_CTEST: begin
        state_nxt = stat.cons_stop ? S_CDONE : S_CPROC;
      end
      S_CPROC: begin
        // Cancelled entries are dropped without a result beat.
        if (!stat.entry_active) begin
          cmd.pop   = 1'b1;
          state_nxt = S_CTEST;
        end else if (stat.out_free) begin
          cmd.fill_exec = 1'b1;
          state_nxt     = S_CTEST;
        end
      end
      S_CDONE: begin
        if (stat.out_free) begin
          cmd.done_exec = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

endmodule

/* rtl/core/plfm_dp.sv */
// Datapath of the order matcher: item registers, queue slot memories, ring
// head/count table, live-order location table and the result register.
// Depends on plfm_pkg.
module plfm_dp
  import plfm_pkg::*;
#(
  parameter int PRICE_LEVELS = 64,
  parameter int LEVEL_DEPTH  = 32,
  parameter int MAX_ORDERS   = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  plfm_cmd_t   cmd,
  output plfm_stat_t  stat,
  input  logic [1:0]  in_command,
  input  logic        in_side,
  input  logic [11:0] in_ord_id,
  input  logic [5:0]  in_price_level,
  input  logic [31:0] in_exec_price,
  input  logic [31:0] in_quantity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_status,
  output logic [11:0] out_buy_order_id,
  output logic [11:0] out_sell_order_id,
  output logic [31:0] out_fill_price,
  output logic [31:0] out_fill_quantity,
  output logic [31:0] out_remaining_quantity,
  output logic        out_level_now_empty,
  output logic        out_last
);

  localparam int LVL_W     = $clog2(PRICE_LEVELS);
  localparam int SLOT_W    = $clog2(LEVEL_DEPTH);
  localparam int CNT_W     = $clog2(LEVEL_DEPTH + 1);
  localparam int LOC_W     = $clog2(MAX_ORDERS);
  localparam int RING_W    = LVL_W + 1;
  localparam int HT_DEPTH  = 2 ** RING_W;
  localparam int ENT_AW    = RING_W + SLOT_W;
  localparam int ENT_DEPTH = 2 ** ENT_AW;
  localparam int LOC_DW    = 2 + LVL_W + SLOT_W;
  localparam int HT_DW     = SLOT_W + CNT_W;
  localparam int CLR_N     = (MAX_ORDERS > HT_DEPTH) ? MAX_ORDERS : HT_DEPTH;
  localparam int CLR_W     = $clog2(CLR_N);

  // Item registers; qty_r doubles as the remaining incoming quantity.
  logic [1:0]  cmd_r;
  logic        side_r;
  logic [11:0] id_r;
  logic [5:0]  lvl_r;
  logic [31:0] price_r;
  logic [31:0] qty_r, qty_nxt;

  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CLR_W-1:0]  clr_idx_r;

  logic [LOC_DW-1:0] loc_mem [MAX_ORDERS];
  logic [HT_DW-1:0]  ht_mem  [HT_DEPTH];
  logic [43:0]       ent_mem [ENT_DEPTH];
  logic              act_mem [ENT_DEPTH];

  logic [LOC_DW-1:0] loc_rd_r;
  logic [HT_DW-1:0]  ht_rd_r;
  logic [43:0]       ent_rd_r;
  logic              act_rd_r;

  logic              loc_we, ht_we, ent_we, act_we, act_wd;
  logic [LOC_W-1:0]  loc_wa;
  logic [LOC_DW-1:0] loc_wd;
  logic [RING_W-1:0] ht_wa;
  logic [HT_DW-1:0]  ht_wd;
  logic [ENT_AW-1:0] ent_wa, act_wa;
  logic [43:0]       ent_wd;

  logic [31:0]       lvl_ext, id_ext, e_id_ext, clr_ext;
  logic [LVL_W-1:0]  lvl_idx;
  logic [LOC_W-1:0]  loc_idx;
  logic [RING_W-1:0] ring_own, ring_book, ht_ra;
  logic              lvl_oob, id_oob;

  logic              loc_valid, loc_side;
  logic [LVL_W-1:0]  loc_lvl;
  logic [SLOT_W-1:0] loc_slot;
  logic [SLOT_W-1:0] ht_head;
  logic [CNT_W-1:0]  ht_count;
  logic [CNT_W:0]    slot_sum;
  logic [SLOT_W-1:0] add_slot;
  logic              add_ok, cancel_hit;

  logic [11:0]       e_id;
  logic [31:0]       e_qty, m_qty, e_left;
  logic              e_gone;
  logic [SLOT_W-1:0] head_inc;

  logic        out_valid_r;
  logic [1:0]  kind_r, status_r;
  logic [11:0] buy_r, sell_r;
  logic [31:0] fprice_r, fqty_r, rem_r;
  logic        empty_r, last_r;

  assign lvl_ext   = {26'd0, lvl_r};
  assign id_ext    = {20'd0, id_r};
  assign lvl_idx   = lvl_ext[LVL_W-1:0];
  assign loc_idx   = id_ext[LOC_W-1:0];
  assign lvl_oob   = lvl_ext >= 32'(PRICE_LEVELS);
  assign id_oob    = id_ext >= 32'(MAX_ORDERS);
  assign ring_own  = {side_r, lvl_idx};
  assign ring_book = {~side_r, lvl_idx};
  assign ht_ra     = (cmd_r == CMD_CONSUME) ? ring_book : ring_own;
  assign clr_ext   = {{(32-CLR_W){1'b0}}, clr_idx_r};

  assign {loc_valid, loc_side, loc_lvl, loc_slot} = loc_rd_r;
  assign {ht_head, ht_count} = ht_rd_r;

  // Tail slot of the ring: head plus count, wrapped once.
  assign slot_sum = (CNT_W+1)'(ht_head) + (CNT_W+1)'(ht_count);
  always_comb begin
    logic [CNT_W:0] wrapped;
    wrapped  = (slot_sum >= (CNT_W+1)'(LEVEL_DEPTH)) ?
               slot_sum - (CNT_W+1)'(LEVEL_DEPTH) : slot_sum;
    add_slot = wrapped[SLOT_W-1:0];
  end

  assign add_ok     = !lvl_oob && !id_oob && (ht_count < CNT_W'(LEVEL_DEPTH));
  assign cancel_hit = !id_oob && loc_valid;

  assign e_id     = ent_rd_r[43:32];
  assign e_qty    = ent_rd_r[31:0];
  assign e_id_ext = {20'd0, e_id};
  assign m_qty    = (qty_r < e_qty) ? qty_r : e_qty;
  assign e_left   = e_qty - m_qty;
  assign e_gone   = (e_left == 32'd0);
  assign head_inc = (head_r == SLOT_W'(LEVEL_DEPTH - 1)) ? '0 : head_r + SLOT_W'(1);

  assign stat.clr_last     = (clr_ext == 32'(CLR_N - 1));
  assign stat.out_free     = !out_valid_r || out_ready;
  assign stat.cmd          = cmd_r;
  assign stat.cons_stop    = lvl_oob || (qty_r == 32'd0) || (count_r == '0);
  assign stat.entry_active = act_rd_r;

  // Write ports of the tables; the controller issues at most one operation a cycle.
  always_comb begin
    loc_we = 1'b0;  loc_wa = loc_idx;  loc_wd = '0;
    ht_we  = 1'b0;  ht_wa  = ring_own; ht_wd  = '0;
    ent_we = 1'b0;  ent_wa = {ring_own, add_slot}; ent_wd = {id_r, qty_r};
    act_we = 1'b0;  act_wa = {ring_own, add_slot}; act_wd = 1'b1;
    if (cmd.clr_we) begin
      loc_we = clr_ext < 32'(MAX_ORDERS);
      loc_wa = clr_idx_r[LOC_W-1:0];
      ht_we  = clr_ext < 32'(HT_DEPTH);
      ht_wa  = clr_idx_r[RING_W-1:0];
    end
    if (cmd.add_exec && add_ok) begin
      ent_we = 1'b1;
      act_we = 1'b1;
      ht_we  = 1'b1;
      ht_wd  = {ht_head, ht_count + CNT_W'(1)};
      // A duplicate id keeps the location of its first entry.
      loc_we = !loc_valid;
      loc_wd = {1'b1, side_r, lvl_idx, add_slot};
    end
    if (cmd.cancel_exec && cancel_hit) begin
      act_we = 1'b1;
      act_wa = {loc_side, loc_lvl, loc_slot};
      act_wd = 1'b0;
      loc_we = 1'b1;
    end
    if (cmd.fill_exec) begin
      ent_we = 1'b1;
      ent_wa = {ring_book, head_r};
      ent_wd = {e_id, e_left};
      loc_we = e_gone && (e_id_ext < 32'(MAX_ORDERS));
      loc_wa = e_id_ext[LOC_W-1:0];
    end
    if (cmd.done_exec && !lvl_oob) begin
      ht_we = 1'b1;
      ht_wa = ring_book;
      ht_wd = {head_r, count_r};
    end
  end

  always_ff @(posedge clk) begin
    if (loc_we) loc_mem[loc_wa] <= loc_wd;
    if (ht_we)  ht_mem[ht_wa]   <= ht_wd;
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    if (act_we) act_mem[act_wa] <= act_wd;
    loc_rd_r <= loc_mem[loc_idx];
    ht_rd_r  <= ht_mem[ht_ra];
    ent_rd_r <= ent_mem[{ring_book, head_r}];
    act_rd_r <= act_mem[{ring_book, head_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_idx_r <= '0;
    else if (cmd.clr_we) clr_idx_r <= clr_idx_r + CLR_W'(1);
  end

  // Ring pointer of the level under consumption and the remaining incoming quantity.
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    qty_nxt   = qty_r;
    if (cmd.load_item) qty_nxt = in_quantity;
    if (cmd.ht_load) begin
      head_nxt  = ht_head;
      count_nxt = ht_count;
    end
    if (cmd.fill_exec) qty_nxt = qty_r - m_qty;
    if (cmd.pop || (cmd.fill_exec && e_gone)) begin
      head_nxt  = head_inc;
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cmd_r <= '0;
    else if (cmd.load_item) cmd_r <= in_command;
    if (cmd.load_item) begin
      side_r  <= in_side;
      id_r    <= in_ord_id;
      lvl_r   <= in_price_level;
      price_r <= in_exec_price;
    end
    qty_r   <= qty_nxt;
    head_r  <= head_nxt;
    count_r <= count_nxt;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.add_exec || cmd.cancel_exec || cmd.fill_exec || cmd.done_exec) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.add_exec || cmd.cancel_exec || cmd.fill_exec || cmd.done_exec) begin
      kind_r   <= KIND_ADD;
      status_r <= ST_OK;
      buy_r    <= '0;
      sell_r   <= '0;
      fprice_r <= '0;
      fqty_r   <= '0;
      rem_r    <= '0;
      empty_r  <= 1'b0;
      last_r   <= 1'b1;
      if (cmd.add_exec) begin
        status_r <= add_ok ? ST_OK : ST_REJECT;
      end
      if (cmd.cancel_exec) begin
        kind_r   <= KIND_CANCEL;
        status_r <= cancel_hit ? ST_OK : ST_NOT_FOUND;
      end
      if (cmd.fill_exec) begin
        kind_r   <= KIND_FILL;
        buy_r    <= side_r ? e_id : id_r;
        sell_r   <= side_r ? id_r : e_id;
        fprice_r <= price_r;
        fqty_r   <= m_qty;
        last_r   <= 1'b0;
      end
      if (cmd.done_exec) begin
        kind_r   <= KIND_DONE;
        status_r <= lvl_oob ? ST_REJECT : ST_OK;
        rem_r    <= qty_r;
        empty_r  <= lvl_oob || (count_r == '0);
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_kind               = kind_r;
  assign out_status             = status_r;
  assign out_buy_order_id       = buy_r;
  assign out_sell_order_id      = sell_r;
  assign out_fill_price         = fprice_r;
  assign out_fill_quantity      = fqty_r;
  assign out_remaining_quantity = rem_r;
  assign out_level_now_empty    = empty_r;
  assign out_last               = last_r;

endmodule

/* rtl/core/price_level_fifo_order_matcher.sv */
// Add and cancel: the item passes lookup and execute, then the next item can be taken.
// Consume: the ring head and count are loaded, then each queue entry visited is read
// and updated in the slot memory, then the done beat follows.
// A stalled result register holds the walk at a live entry until its beat is taken.
// After reset a clearing pass over max(MAX_ORDERS, 2 * 2**clog2(PRICE_LEVELS)) table
// addresses empties all queues and the location table; in_ch.ready stays low.
module price_level_fifo_order_matcher
  import plfm_pkg::*;
#(
  parameter int PRICE_LEVELS = 64,
  parameter int LEVEL_DEPTH  = 32,
  parameter int MAX_ORDERS   = 4096
) (
  input logic         clk,
  input logic         rst_n,
  plfm_in_if.sink     in_ch,
  plfm_out_if.source  out_ch
);

  plfm_cmd_t  cmd;
  plfm_stat_t stat;

  plfm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  plfm_dp #(
    .PRICE_LEVELS (PRICE_LEVELS),
    .LEVEL_DEPTH  (LEVEL_DEPTH),
    .MAX_ORDERS   (MAX_ORDERS)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .stat                   (stat),
    .in_command             (in_ch.command),
    .in_side                (in_ch.side),
    .in_ord_id              (in_ch.ord_id),
    .in_price_level         (in_ch.price_level),
    .in_exec_price          (in_ch.exec_price),
    .in_quantity            (in_ch.quantity),
    .out_valid              (out_ch.valid),
    .out_ready              (out_ch.ready),
    .out_kind               (out_ch.kind),
    .out_status             (out_ch.status),
    .out_buy_order_id       (out_ch.buy_order_id),
    .out_sell_order_id      (out_ch.sell_order_id),
    .out_fill_price         (out_ch.fill_price),
    .out_fill_quantity      (out_ch.fill_quantity),
    .out_remaining_quantity (out_ch.remaining_quantity),
    .out_level_now_empty    (out_ch.level_now_empty),
    .out_last               (out_ch.last)
  );

endmodule

/* rtl/core/plfm_checker.sv */
// Port-level checks for the order matcher and the bind that attaches them.
// Depends on plfm_pkg and price_level_fifo_order_matcher.
module plfm_checker
  import plfm_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [1:0] out_status,
  input logic       out_last
);

  // The clearing pass keeps the command channel closed right after reset.
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("command channel open during clearing pass");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_fill_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_FILL |-> !out_last && out_status == ST_OK)
    else $error("fill beat marked last or with nonzero status");

  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_ADD || out_kind == KIND_CANCEL || out_kind == KIND_DONE)
    |-> out_last)
    else $error("single or closing beat not marked last");

  // A pending fill means a consume is still walking its level.
  a_busy_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_FILL |-> !in_ready)
    else $error("command accepted during a consume");

endmodule

bind price_level_fifo_order_matcher plfm_checker u_plfm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_kind   (out_ch.kind),
  .out_status (out_ch.status),
  .out_last   (out_ch.last)
);
